[sv/bpts_pkg.sv]
// Package for the bitmap priority task scheduler.
// Holds item and result word types, item and status codes and sizes.
// No dependencies.
package bpts_pkg;

  localparam int NumPrio    = 64;
  localparam int PrioW      = 6;
  localparam int LowestPrio = 63;
  localparam int MaxTasks   = 32;
  localparam int SlotW      = 7;
  localparam int DelayBits  = 16;
  localparam int WalkW      = 7;

  localparam logic [2:0] K_CREATE    = 3'd0;
  localparam logic [2:0] K_TICK      = 3'd1;
  localparam logic [2:0] K_INT_ENTER = 3'd2;
  localparam logic [2:0] K_INT_EXIT  = 3'd3;
  localparam logic [2:0] K_SCHEDULE  = 3'd4;
  localparam logic [2:0] K_START     = 3'd5;
  localparam logic [2:0] K_SET_WAIT  = 3'd6;
  localparam logic [2:0] K_UNUSED    = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_BAD_PRIO = 2'd2;
  localparam logic [1:0] ST_IN_USE   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  prio;
    logic [15:0] delay_ticks;
    logic        suspend;
    logic        sched_locked;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        switch_req;
    logic [5:0]  highest_ready;
    logic [5:0]  current_prio;
    logic [7:0]  nesting_level;
    logic [31:0] switch_count;
  } out_word_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [2:0] low_bit8(input logic [7:0] v);
    logic [2:0] idx;
    logic       found;
    idx   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (v[i] && !found) begin
        idx   = 3'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

[sv/bpts_resolve.sv]
// Two-level highest-ready resolver: group bitmap, then row bitmap.
// Depends on bpts_pkg.
module bpts_resolve (
  input  logic [bpts_pkg::NumPrio-1:0] ready_mask,
  output logic [bpts_pkg::PrioW-1:0]   highest
);
  import bpts_pkg::*;

  logic [7:0] group;
  logic [2:0] gy;
  logic [7:0] row;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      group[i] = |ready_mask[i*8 +: 8];
    end
  end

  assign gy      = low_bit8(group);
  assign row     = ready_mask[gy*8 +: 8];
  assign highest = {gy, low_bit8(row)};

endmodule

[sv/bitmap_priority_task_scheduler_core.sv]
// Top level of the bitmap priority task scheduler.
// Depends on bpts_pkg and bpts_resolve.
// One word in gives one result word out. A tick walks the 64-entry delay
// memory through one shared decrementer, one entry per cycle, and its result
// word is loaded when the walk has passed the last entry. Schedule and
// interrupt exit go through a scheduling step before the output state, and
// every other item goes from the execute step straight to it. A result word
// that the receiver has not yet taken holds the next result, and the
// sequencer waits in its output state meanwhile.
// The block accepts a new word only when its sequencer is idle, but it does
// so while an earlier result still waits in the output register.
module bitmap_priority_task_scheduler_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpts_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpts_pkg::out_word_t out_data
);
  import bpts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_TICK  = 5'b00100,
    S_SCHED = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t               state;
  in_word_t             item;
  logic [NumPrio-1:0]   ready_mask;
  logic [NumPrio-1:0]   created_mask;
  logic [NumPrio-1:0]   suspended_mask;
  logic [SlotW-1:0]     free_slots;
  logic [PrioW-1:0]     running_prio;
  logic [7:0]           int_nesting;
  logic [31:0]          switches;
  logic                 started;
  logic [1:0]           status;
  logic                 sw;
  logic [WalkW-1:0]     cnt;

  logic [DelayBits-1:0] delay_mem [NumPrio];
  logic [DelayBits-1:0] rd_data;

  logic [PrioW-1:0]     highest;
  logic                 mem_we;
  logic [PrioW-1:0]     mem_waddr;
  logic [DelayBits-1:0] mem_wdata;
  logic [PrioW-1:0]     tp;
  logic                 tick_act;
  logic [DelayBits-1:0] tick_dec;
  logic                 tick_zero;
  logic [DelayBits-1:0] dly;
  logic                 bad_prio;
  logic                 is_created;
  logic [1:0]           exec_status;
  logic                 exec_sw;
  state_t               exec_next;

  bpts_resolve u_resolve (
    .ready_mask (ready_mask),
    .highest    (highest)
  );

  assign in_ready   = (state == S_IDLE);
  assign dly        = item.delay_ticks[DelayBits-1:0];
  assign bad_prio   = {1'b0, item.prio} > 7'(LowestPrio);
  assign is_created = created_mask[item.prio];

  // Shared decrementer for the tick walk; entry cnt-1 is processed.
  assign tp        = PrioW'(cnt - 7'd1);
  assign tick_act  = (cnt != '0) && (tp != PrioW'(LowestPrio)) && created_mask[tp]
                     && (rd_data != '0);
  assign tick_dec  = rd_data - DelayBits'(1);
  assign tick_zero = (tick_dec == '0);

  // status, switch flag and next state of the execute step
  always_comb begin
    exec_status = ST_OK;
    exec_sw     = 1'b0;
    exec_next   = S_OUT;
    case (item.kind) inside
      K_CREATE: begin
        if (bad_prio) begin
          exec_status = ST_BAD_PRIO;
        end else if (is_created) begin
          exec_status = ST_IN_USE;
        end else if (free_slots == '0) begin
          exec_status = ST_NO_SLOT;
        end
      end
      K_TICK: exec_next = S_TICK;
      K_INT_EXIT, K_SCHEDULE: exec_next = S_SCHED;
      K_START: exec_sw = !started;
      K_SET_WAIT: begin
        if (bad_prio) begin
          exec_status = ST_BAD_PRIO;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item.prio;
    mem_wdata = '0;
    if (state == S_EXEC) begin
      if (item.kind == K_CREATE && !bad_prio && !is_created && free_slots != '0) begin
        mem_we = 1'b1;
      end else if (item.kind == K_SET_WAIT && !bad_prio && is_created) begin
        mem_we    = 1'b1;
        mem_wdata = dly;
      end
    end else if (state == S_TICK && tick_act) begin
      mem_we    = 1'b1;
      mem_waddr = tp;
      mem_wdata = tick_zero ? DelayBits'(suspended_mask[tp]) : tick_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= delay_mem[cnt[PrioW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ready_mask     <= '0;
      created_mask   <= '0;
      suspended_mask <= '0;
      free_slots     <= SlotW'(MaxTasks);
      running_prio   <= '0;
      int_nesting    <= '0;
      switches       <= '0;
      started        <= 1'b0;
      cnt            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state != S_OUT && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= exec_status;
          sw     <= exec_sw;
          cnt    <= '0;
          state  <= exec_next;
          case (item.kind)
            K_CREATE: begin
              if (!bad_prio && !is_created && free_slots != '0) begin
                free_slots                 <= free_slots - 7'd1;
                created_mask[item.prio]    <= 1'b1;
                suspended_mask[item.prio]  <= 1'b0;
                ready_mask[item.prio]      <= 1'b1;
              end
            end
            K_INT_ENTER: begin
              if (int_nesting != 8'd255) begin
                int_nesting <= int_nesting + 8'd1;
              end
            end
            K_INT_EXIT: begin
              if (int_nesting != '0) begin
                int_nesting <= int_nesting - 8'd1;
              end
            end
            K_START: begin
              if (!started) begin
                running_prio <= highest;
                started      <= 1'b1;
              end
            end
            K_SET_WAIT: begin
              if (!bad_prio && is_created) begin
                suspended_mask[item.prio] <= item.suspend;
                ready_mask[item.prio]     <= (dly == '0) && !item.suspend;
              end
            end
            default: ;
          endcase
        end
        S_TICK: begin
          cnt <= cnt + 7'd1;
          if (tick_act && tick_zero && !suspended_mask[tp]) begin
            ready_mask[tp] <= 1'b1;
          end
          if (cnt == 7'(NumPrio)) begin
            state <= S_OUT;
          end
        end
        S_SCHED: begin
          if (int_nesting == '0 && !item.sched_locked && started
              && highest != running_prio) begin
            running_prio <= highest;
            switches     <= switches + 32'd1;
            sw           <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous result word has left
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.status        <= status;
            out_data.switch_req    <= sw;
            out_data.highest_ready <= highest;
            out_data.current_prio  <= running_prio;
            out_data.nesting_level <= int_nesting;
            out_data.switch_count  <= switches;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/bpts_checker.sv]
// Port-level checker for the scheduler core, with its bind statement.
// Depends on bpts_pkg and bitmap_priority_task_scheduler_core.
module bpts_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bpts_pkg::out_word_t out_data
);
  import bpts_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: no second accept right after one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a failed create or set_wait never requests a switch
  a_status_sw: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> !out_data.switch_req)
    else $error("switch requested with error status");

  // no result can appear the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind bitmap_priority_task_scheduler_core bpts_checker u_bpts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/tb_top.sv]
// Testbench for bitmap_priority_task_scheduler_core.
// Depends on bpts_pkg and the core; predicts each result word in-line and
// checks it against the block under random sender bursts and receiver stalls.
`timescale 1ns / 1ps
module tb_top;
  import bpts_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  // predicted scheduler state
  logic [7:0]  grp;
  logic [7:0]  rows [8];
  logic [63:0] created;
  logic [15:0] delays [64];
  logic [63:0] susp_mask;
  int          slots_left;
  logic [5:0]  run_prio;
  logic [7:0]  nest;
  logic [31:0] sw_total;
  logic        is_started;

  out_word_t   sched_q [$];
  int          fails;
  int          cycles;
  int          burst_left;

  bitmap_priority_task_scheduler_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] first_set(input logic [7:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[i]) return 3'(i);
    end
    return 3'd0;
  endfunction

  function automatic logic [5:0] top_ready();
    logic [2:0] y;
    y = first_set(grp);
    return {y, first_set(rows[y])};
  endfunction

  function automatic void set_rdy(input logic [5:0] p);
    grp[p[5:3]]         = 1'b1;
    rows[p[5:3]][p[2:0]] = 1'b1;
  endfunction

  function automatic void clr_rdy(input logic [5:0] p);
    rows[p[5:3]][p[2:0]] = 1'b0;
    if (rows[p[5:3]] == 8'd0) grp[p[5:3]] = 1'b0;
  endfunction

  function automatic logic resched(input logic locked);
    logic [5:0] h;
    if (nest != 0 || locked || !is_started) return 1'b0;
    h = top_ready();
    if (h == run_prio) return 1'b0;
    run_prio = h;
    sw_total = sw_total + 1;
    return 1'b1;
  endfunction

  function automatic void reset_state();
    grp = '0;
    for (int i = 0; i < 8; i++) rows[i] = '0;
    for (int i = 0; i < 64; i++) delays[i] = '0;
    created    = '0;
    susp_mask  = '0;
    slots_left = MaxTasks;
    run_prio   = '0;
    nest       = '0;
    sw_total   = '0;
    is_started = 1'b0;
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    logic [5:0] p;
    r = '0;
    r.status = ST_OK;
    p = w.prio;
    case (w.kind)
      K_CREATE: begin
        if (int'(p) > LowestPrio) r.status = ST_BAD_PRIO;
        else if (created[p]) r.status = ST_IN_USE;
        else if (slots_left == 0) r.status = ST_NO_SLOT;
        else begin
          slots_left--;
          created[p]   = 1'b1;
          susp_mask[p] = 1'b0;
          delays[p]    = '0;
          set_rdy(p);
        end
      end
      K_TICK: begin
        for (int i = 0; i < 64; i++) begin
          if (i != LowestPrio && created[i] && delays[i] != 0) begin
            delays[i] = delays[i] - 1;
            if (delays[i] == 0) begin
              if (susp_mask[i]) delays[i] = 16'd1;
              else set_rdy(6'(i));
            end
          end
        end
      end
      K_INT_ENTER: if (nest != 8'd255) nest = nest + 1;
      K_INT_EXIT: begin
        if (nest != 0) nest = nest - 1;
        r.switch_req = resched(w.sched_locked);
      end
      K_SCHEDULE: r.switch_req = resched(w.sched_locked);
      K_START: begin
        if (!is_started) begin
          run_prio     = top_ready();
          is_started   = 1'b1;
          r.switch_req = 1'b1;
        end
      end
      K_SET_WAIT: begin
        if (int'(p) > LowestPrio) r.status = ST_BAD_PRIO;
        else if (created[p]) begin
          delays[p]    = w.delay_ticks;
          susp_mask[p] = w.suspend;
          if (w.delay_ticks == 0 && !w.suspend) set_rdy(p);
          else clr_rdy(p);
        end
      end
      default: ;
    endcase
    r.highest_ready = top_ready();
    r.current_prio  = run_prio;
    r.nesting_level = nest;
    r.switch_count  = sw_total;
    return r;
  endfunction

  task automatic send_word(input in_word_t w);
    // idle gap between bursts
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 12) : 1) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_q.push_back(predict_word(w));
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  function automatic in_word_t mk(input logic [2:0] k, input logic [5:0] p,
                                  input logic [15:0] d, input logic s,
                                  input logic l);
    in_word_t w;
    w.kind = k; w.prio = p; w.delay_ticks = d; w.suspend = s; w.sched_locked = l;
    return w;
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    // drop valid left over from an unfinished burst
    if (burst_left != 0) in_valid <= 1'b0;
    burst_left = 0;
    while (sched_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic test_directed();
    send_word(mk(K_SCHEDULE, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_START, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_CREATE, 6'd63, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_CREATE, 6'd10, 16'hffff, 1'b1, 1'b1));
    send_word(mk(K_CREATE, 6'd10, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_CREATE, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_SET_WAIT, 6'd0, 16'd2, 1'b0, 1'b0));
    send_word(mk(K_SET_WAIT, 6'd10, 16'd1, 1'b1, 1'b0));
    send_word(mk(K_SET_WAIT, 6'd33, 16'd5, 1'b1, 1'b0));
    send_word(mk(K_SET_WAIT, 6'd63, 16'd1, 1'b0, 1'b0));
    send_word(mk(K_TICK, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_TICK, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_TICK, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_INT_EXIT, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_INT_ENTER, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_SCHEDULE, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_INT_EXIT, 6'd0, 16'd0, 1'b0, 1'b1));
    send_word(mk(K_SET_WAIT, 6'd10, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_SCHEDULE, 6'd0, 16'd0, 1'b0, 1'b1));
    send_word(mk(K_SCHEDULE, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_START, 6'd0, 16'd0, 1'b0, 1'b0));
    send_word(mk(K_UNUSED, 6'd5, 16'd0, 1'b1, 1'b1));
  endtask

  // nesting past saturation, then a few steps back down
  task automatic test_nesting();
    for (int i = 0; i < 258; i++) send_word(mk(K_INT_ENTER, 6'($urandom), 16'($urandom),
                                             1'($urandom), 1'($urandom)));
    for (int i = 0; i < 4; i++) send_word(mk(K_INT_EXIT, 6'($urandom), 16'($urandom),
                                          1'($urandom), 1'($urandom_range(0, 3) == 0)));
  endtask

  task automatic test_random();
    in_word_t w;
    for (int i = 0; i < 165; i++) begin
      w = in_word_t'(27'($urandom));
      case ($urandom_range(0, 15))
        0, 1, 2:  w.kind = K_CREATE;
        3, 4:     w.kind = K_TICK;
        5:        w.kind = K_INT_ENTER;
        6:        w.kind = K_INT_EXIT;
        7, 8, 9:  w.kind = K_SCHEDULE;
        10, 11, 12, 13: w.kind = K_SET_WAIT;
        14:       w.kind = K_START;
        default: ;
      endcase
      // mostly short delays so tasks wake up within the run
      if ($urandom_range(0, 7) != 0) w.delay_ticks = 16'($urandom_range(0, 4));
      if ($urandom_range(0, 2) != 0) w.sched_locked = 1'b0;
      if ($urandom_range(0, 2) != 0) w.suspend = 1'b0;
      send_word(w);
    end
  endtask

  // receiver: stall on its own pattern, check each accepted word
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (cycles % 300 < 100) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (sched_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = sched_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); fails++;
        end
        if (out_data.switch_req !== e.switch_req) begin
          $error("switch_req exp %0d got %0d", e.switch_req, out_data.switch_req); fails++;
        end
        if (out_data.highest_ready !== e.highest_ready) begin
          $error("highest_ready exp %0d got %0d", e.highest_ready, out_data.highest_ready);
          fails++;
        end
        if (out_data.current_prio !== e.current_prio) begin
          $error("current_prio exp %0d got %0d", e.current_prio, out_data.current_prio);
          fails++;
        end
        if (out_data.nesting_level !== e.nesting_level) begin
          $error("nesting_level exp %0d got %0d", e.nesting_level, out_data.nesting_level);
          fails++;
        end
        if (out_data.switch_count !== e.switch_count) begin
          $error("switch_count exp %0d got %0d", e.switch_count, out_data.switch_count);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fails      = 0;
    cycles     = 0;
    burst_left = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    test_nesting();
    drain();
    repeat (100) @(negedge clk);
    if (fails == 0 && sched_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
